### rtl/cpw_pkg.sv
// shared types, codes and constants of the centronics printer write block
package cpw_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int SHOW_BITS          = 16;
   localparam logic [SHOW_BITS-1:0] SHOW_MAX = '1;

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [31:0] TIMEOUT_RESET = 32'd10000000;
   localparam logic [15:0] STROBE_RESET  = 16'd10;

   typedef enum logic {
      REG_TIMEOUT = 1'b0,
      REG_STROBE  = 1'b1
   } reg_index_type;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_BYTE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_WAITFREE = 3'd1,
      PH_STROBE   = 3'd2,
      PH_WAITACK  = 3'd3,
      PH_BETWEEN  = 3'd4,
      PH_OK       = 3'd5,
      PH_TIMEOUT  = 3'd6,
      PH_ERROR    = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      ST_BUSY    = 2'd0,
      ST_OK      = 2'd1,
      ST_TIMEOUT = 2'd2,
      ST_ERROR   = 2'd3
   } status_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic       last_byte;
      logic       not_busy;
      logic       not_ack;
      logic       not_error;
   } item_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage

### rtl/cpw_front.sv
// front end: takes request words and classifies them into queue entries
module cpw_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_kind,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_last_byte,
   input  logic                      req_line_not_busy,
   input  logic                      req_line_not_ack,
   input  logic                      req_line_not_error,
   input  cpw_pkg::queue_status_type q_status,
   output logic                      push,
   output cpw_pkg::item_type         push_item
);

   always_comb begin
      req_stall = q_status.full;
      push      = req_valid && !q_status.full;
      push_item = '0;
      if (req_kind) begin
         push_item.op        = cpw_pkg::OP_BYTE;
         push_item.data_byte = req_data_byte;
         push_item.last_byte = req_last_byte;
      end else begin
         push_item.op        = cpw_pkg::OP_TICK;
         push_item.not_busy  = req_line_not_busy;
         push_item.not_ack   = req_line_not_ack;
         push_item.not_error = req_line_not_error;
      end
   end

endmodule

### rtl/cpw_queue.sv
// short queue between the front end and the handshake engine
module cpw_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cpw_pkg::item_type         push_item,
   input  logic                      pop,
   output cpw_pkg::item_type         head_item,
   output cpw_pkg::queue_status_type q_status
);

   localparam int DEPTH    = cpw_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   cpw_pkg::item_type   entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] ptr);
      if (ptr == PTR_BITS'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_BITS'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
      q_status.valid = (count_ff != '0);
      q_status.full  = (count_ff == CNT_BITS'(DEPTH));
      head_item      = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue count above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

endmodule

### rtl/cpw_back.sv
// back end: handshake state machine, timers and the response register
module cpw_back #(
   parameter int COUNT_BITS = cpw_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cpw_pkg::queue_status_type q_status,
   input  cpw_pkg::item_type         head_item,
   output logic                      pop,
   input  logic [31:0]               timeout_ticks,
   input  logic [15:0]               strobe_ticks,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_data_lines,
   output logic                      rsp_strobe_active,
   output logic                      rsp_ready_for_byte,
   output logic [1:0]                rsp_transfer_status,
   output logic [15:0]               rsp_bytes_sent
);

   localparam int SB   = cpw_pkg::SHOW_BITS;
   localparam int WIDE = (COUNT_BITS > SB) ? COUNT_BITS : SB;

   cpw_pkg::phase_type   phase_ff, phase_in;
   logic [31:0]          budget_ff, budget_in;
   logic [15:0]          strobe_left_ff, strobe_left_in;
   logic [7:0]           held_byte_ff, held_byte_in;
   logic                 final_ff, final_in;
   logic [COUNT_BITS-1:0] sent_ff, sent_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           data_lines_ff;
   logic                 strobe_active_ff;
   logic                 ready_ff;
   cpw_pkg::status_type  status_ff, status_in;
   logic [SB-1:0]        shown_ff, shown_in;

   logic                 spend;
   logic                 restart;
   logic                 byte_ok;
   logic [15:0]          strobe_dec;
   logic [WIDE-1:0]      sent_wide;

   always_comb begin
      pop            = q_status.valid && (!rsp_valid_ff || !rsp_stall);
      phase_in       = phase_ff;
      budget_in      = budget_ff;
      strobe_left_in = strobe_left_ff;
      held_byte_in   = held_byte_ff;
      final_in       = final_ff;
      sent_in        = sent_ff;
      spend          = 1'b0;
      restart        = (phase_ff inside {cpw_pkg::PH_IDLE, cpw_pkg::PH_OK,
                                         cpw_pkg::PH_TIMEOUT, cpw_pkg::PH_ERROR});
      byte_ok        = restart || (phase_ff == cpw_pkg::PH_BETWEEN);
      strobe_dec     = (strobe_left_ff != '0) ? strobe_left_ff - 16'd1 : strobe_left_ff;

      if (head_item.op == cpw_pkg::OP_BYTE) begin
         if (restart) begin
            budget_in = timeout_ticks;
            sent_in   = '0;
         end
         if (byte_ok) begin
            held_byte_in = head_item.data_byte;
            final_in     = head_item.last_byte;
            phase_in     = cpw_pkg::PH_WAITFREE;
         end
      end else begin
         unique case (phase_ff)
            cpw_pkg::PH_WAITFREE: begin
               if (head_item.not_busy) begin
                  if (sent_ff != '1) begin
                     sent_in = sent_ff + COUNT_BITS'(1);
                  end
                  strobe_left_in = (strobe_ticks == '0) ? 16'd1 : strobe_ticks;
                  phase_in       = cpw_pkg::PH_STROBE;
               end else begin
                  spend = 1'b1;
               end
            end
            cpw_pkg::PH_STROBE: begin
               strobe_left_in = strobe_dec;
               if (strobe_dec == '0) begin
                  phase_in = cpw_pkg::PH_WAITACK;
               end
            end
            cpw_pkg::PH_WAITACK: begin
               if (head_item.not_busy || !head_item.not_ack) begin
                  if (!head_item.not_error) begin
                     phase_in = cpw_pkg::PH_ERROR;
                  end else if (final_ff) begin
                     phase_in = cpw_pkg::PH_OK;
                  end else begin
                     phase_in = cpw_pkg::PH_BETWEEN;
                  end
               end else begin
                  spend = 1'b1;
               end
            end
            default: begin
            end
         endcase
         if (spend) begin
            if (budget_ff == '0) begin
               phase_in = cpw_pkg::PH_TIMEOUT;
            end else begin
               budget_in = budget_ff - 32'd1;
            end
         end
      end

      unique case (phase_in)
         cpw_pkg::PH_OK:      status_in = cpw_pkg::ST_OK;
         cpw_pkg::PH_TIMEOUT: status_in = cpw_pkg::ST_TIMEOUT;
         cpw_pkg::PH_ERROR:   status_in = cpw_pkg::ST_ERROR;
         default:             status_in = cpw_pkg::ST_BUSY;
      endcase

      sent_wide = WIDE'(sent_in);
      shown_in  = (sent_wide > WIDE'(cpw_pkg::SHOW_MAX)) ? cpw_pkg::SHOW_MAX
                                                         : sent_wide[SB-1:0];

      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= cpw_pkg::PH_IDLE;
         budget_ff      <= '0;
         strobe_left_ff <= '0;
         held_byte_ff   <= '0;
         final_ff       <= 1'b0;
         sent_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff       <= phase_in;
            budget_ff      <= budget_in;
            strobe_left_ff <= strobe_left_in;
            held_byte_ff   <= held_byte_in;
            final_ff       <= final_in;
            sent_ff        <= sent_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_lines_ff    <= held_byte_in;
         strobe_active_ff <= (phase_in == cpw_pkg::PH_STROBE);
         ready_ff         <= (phase_in inside {cpw_pkg::PH_IDLE, cpw_pkg::PH_BETWEEN,
                                               cpw_pkg::PH_OK, cpw_pkg::PH_TIMEOUT,
                                               cpw_pkg::PH_ERROR});
         status_ff        <= status_in;
         shown_ff         <= shown_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data_lines      = data_lines_ff;
   assign rsp_strobe_active   = strobe_active_ff;
   assign rsp_ready_for_byte  = ready_ff;
   assign rsp_transfer_status = status_ff;
   assign rsp_bytes_sent      = shown_ff;

   a_byte_starts: assert property (@(posedge clock) disable iff (reset)
      (pop && head_item.op == cpw_pkg::OP_BYTE && phase_ff == cpw_pkg::PH_IDLE)
      |=> phase_ff == cpw_pkg::PH_WAITFREE)
      else $error("byte in idle did not start a transfer");

   a_strobe_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == cpw_pkg::PH_STROBE |-> strobe_left_ff != '0)
      else $error("strobe phase with empty strobe counter");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !pop |=> $stable(sent_ff) && $stable(phase_ff))
      else $error("state changed without a queue word");

   a_rsp_after_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("word taken from queue gave no response");

endmodule

### rtl/centronics_printer_write.sv
// Host side of the Centronics printer handshake. Each request word is a timer tick with the
// sampled nBUSY/nACK/nERROR lines or a byte to print; each one gives exactly one response word
// with the data lines, strobe, ready, transfer status and sent count after that word. One word
// is taken every clock cycle while the queue is not full: a two-word queue sits between the
// request side and the handshake engine, which retires one queued word per cycle into its
// response register while rsp_stall is low, so the rate is limited only by rsp_stall.
// Registers: timeout_ticks at byte address 0, strobe_ticks at byte address 4.
module centronics_printer_write #(
   parameter int COUNT_BITS = cpw_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_last_byte,
   input  logic                              req_line_not_busy,
   input  logic                              req_line_not_ack,
   input  logic                              req_line_not_error,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_data_lines,
   output logic                              rsp_strobe_active,
   output logic                              rsp_ready_for_byte,
   output logic [1:0]                        rsp_transfer_status,
   output logic [15:0]                       rsp_bytes_sent,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cpw_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [cpw_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [cpw_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   logic [31:0]               timeout_ff, timeout_in;
   logic [15:0]               strobe_ff, strobe_in;
   cpw_pkg::reg_index_type    csr_index;
   logic                      csr_write;

   cpw_pkg::queue_status_type q_status;
   cpw_pkg::item_type         push_item;
   cpw_pkg::item_type         head_item;
   logic                      push;
   logic                      pop;

   always_comb begin
      csr_index  = cpw_pkg::reg_index_type'(csr_paddr[2]);
      csr_write  = csr_psel && csr_penable && csr_pwrite;
      csr_pready = 1'b1;
      timeout_in = timeout_ff;
      strobe_in  = strobe_ff;
      unique case (csr_index)
         cpw_pkg::REG_TIMEOUT: begin
            csr_prdata = timeout_ff;
            if (csr_write) begin
               timeout_in = csr_pwdata;
            end
         end
         cpw_pkg::REG_STROBE: begin
            csr_prdata = {16'd0, strobe_ff};
            if (csr_write) begin
               strobe_in = csr_pwdata[15:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= cpw_pkg::TIMEOUT_RESET;
         strobe_ff  <= cpw_pkg::STROBE_RESET;
      end else begin
         timeout_ff <= timeout_in;
         strobe_ff  <= strobe_in;
      end
   end

   cpw_front u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .req_line_not_busy  (req_line_not_busy),
      .req_line_not_ack   (req_line_not_ack),
      .req_line_not_error (req_line_not_error),
      .q_status           (q_status),
      .push               (push),
      .push_item          (push_item)
   );

   cpw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   cpw_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_status            (q_status),
      .head_item           (head_item),
      .pop                 (pop),
      .timeout_ticks       (timeout_ff),
      .strobe_ticks        (strobe_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data_lines      (rsp_data_lines),
      .rsp_strobe_active   (rsp_strobe_active),
      .rsp_ready_for_byte  (rsp_ready_for_byte),
      .rsp_transfer_status (rsp_transfer_status),
      .rsp_bytes_sent      (rsp_bytes_sent)
   );

endmodule

### tb/tb_top.sv
// self-checking testbench of the centronics printer write block
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cpw_pkg::*;

   localparam int CYCLE_LIMIT = 20000;
   localparam int LONG_HOLD   = 300;
   localparam int IDLE_PCT    = 23;

   typedef struct packed {
      logic [7:0]  lines;
      logic        strobe;
      logic        ready;
      status_type  status;
      logic [15:0] sent;
   } view_type;

   typedef struct {
      item_type word;
      bit       typed;
      view_type view;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid          = 1'b0;
   logic                     req_stall;
   logic                     req_kind           = 1'b0;
   logic [7:0]               req_data_byte      = '0;
   logic                     req_last_byte      = 1'b0;
   logic                     req_line_not_busy  = 1'b0;
   logic                     req_line_not_ack   = 1'b1;
   logic                     req_line_not_error = 1'b1;
   logic                     rsp_valid;
   logic                     rsp_stall          = 1'b0;
   logic [7:0]               rsp_data_lines;
   logic                     rsp_strobe_active;
   logic                     rsp_ready_for_byte;
   logic [1:0]               rsp_transfer_status;
   logic [15:0]              rsp_bytes_sent;
   logic                     csr_psel           = 1'b0;
   logic                     csr_penable        = 1'b0;
   logic                     csr_pwrite         = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr          = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata         = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // typed expectation travelling with the word on the bus
   bit       typed_now  = 1'b0;
   view_type typed_view = '0;

   bit          idle_on     = 1'b1;
   int unsigned hold_asks   = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left   = 0;

   int unsigned cycle_count  = 0;
   int unsigned errors       = 0;
   int unsigned words_in     = 0;
   int unsigned words_out    = 0;
   int unsigned peak_sent    = 0;
   int unsigned seen_ok      = 0;
   int unsigned seen_timeout = 0;
   int unsigned seen_error   = 0;

   view_type expected_views[$];

   // printer-side state as the block should hold it
   logic [31:0]                   timeout_shadow = TIMEOUT_RESET;
   logic [15:0]                   strobe_shadow  = STROBE_RESET;
   phase_type                     pr_phase       = PH_IDLE;
   logic [32:0]                   pr_budget      = '0;
   logic [15:0]                   pr_strobe_left = '0;
   logic [7:0]                    pr_held        = '0;
   logic                          pr_final       = 1'b0;
   logic [COUNT_BITS_DEFAULT-1:0] pr_sent        = '0;

   centronics_printer_write u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_data_byte       (req_data_byte),
      .req_last_byte       (req_last_byte),
      .req_line_not_busy   (req_line_not_busy),
      .req_line_not_ack    (req_line_not_ack),
      .req_line_not_error  (req_line_not_error),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data_lines      (rsp_data_lines),
      .rsp_strobe_active   (rsp_strobe_active),
      .rsp_ready_for_byte  (rsp_ready_for_byte),
      .rsp_transfer_status (rsp_transfer_status),
      .rsp_bytes_sent      (rsp_bytes_sent),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic void spend_budget();
      if (pr_budget == '0) begin
         pr_phase = PH_TIMEOUT;
      end else begin
         pr_budget = pr_budget - 33'd1;
      end
   endfunction

   function automatic view_type step_printer(item_type w);
      view_type v;
      if (w.op == OP_BYTE) begin
         if (pr_phase == PH_IDLE || pr_phase >= PH_OK) begin
            pr_budget = {1'b0, timeout_shadow};
            pr_sent   = '0;
         end
         if (pr_phase == PH_IDLE || pr_phase >= PH_BETWEEN) begin
            pr_held  = w.data_byte;
            pr_final = w.last_byte;
            pr_phase = PH_WAITFREE;
         end
      end else begin
         case (pr_phase)
            PH_WAITFREE: begin
               if (w.not_busy) begin
                  if (pr_sent != '1) pr_sent = pr_sent + COUNT_BITS_DEFAULT'(1);
                  pr_strobe_left = (strobe_shadow == '0) ? 16'd1 : strobe_shadow;
                  pr_phase = PH_STROBE;
               end else begin
                  spend_budget();
               end
            end
            PH_STROBE: begin
               if (pr_strobe_left != '0) pr_strobe_left = pr_strobe_left - 16'd1;
               if (pr_strobe_left == '0) pr_phase = PH_WAITACK;
            end
            PH_WAITACK: begin
               if (w.not_busy || !w.not_ack) begin
                  if (!w.not_error) pr_phase = PH_ERROR;
                  else if (pr_final) pr_phase = PH_OK;
                  else pr_phase = PH_BETWEEN;
               end else begin
                  spend_budget();
               end
            end
            default: begin
            end
         endcase
      end
      v.lines  = pr_held;
      v.strobe = (pr_phase == PH_STROBE);
      v.ready  = (pr_phase == PH_IDLE || pr_phase >= PH_BETWEEN);
      case (pr_phase)
         PH_OK:      v.status = ST_OK;
         PH_TIMEOUT: v.status = ST_TIMEOUT;
         PH_ERROR:   v.status = ST_ERROR;
         default:    v.status = ST_BUSY;
      endcase
      v.sent = (pr_sent > SHOW_MAX) ? SHOW_MAX : pr_sent[SHOW_BITS-1:0];
      return v;
   endfunction

   function automatic void flag_field(string what, int unsigned want, int unsigned got);
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      errors++;
   endfunction

   always @(posedge clock) begin
      view_type calc;
      view_type got;
      view_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            calc = step_printer(item_type'{op_type'(req_kind), req_data_byte, req_last_byte,
                                           req_line_not_busy, req_line_not_ack,
                                           req_line_not_error});
            expected_views.push_back(typed_now ? typed_view : calc);
            words_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_data_lines, rsp_strobe_active, rsp_ready_for_byte,
                    status_type'(rsp_transfer_status), rsp_bytes_sent};
            words_out++;
            if (expected_views.size() == 0) begin
               $display("%0t: response word with none expected, got %0h", $time, got);
               errors++;
            end else begin
               want = expected_views.pop_front();
               if (got.lines !== want.lines) flag_field("data_lines", want.lines, got.lines);
               if (got.strobe !== want.strobe)
                  flag_field("strobe_active", want.strobe, got.strobe);
               if (got.ready !== want.ready)
                  flag_field("ready_for_byte", want.ready, got.ready);
               if (got.status !== want.status)
                  flag_field("transfer_status", want.status, got.status);
               if (got.sent !== want.sent) flag_field("bytes_sent", want.sent, got.sent);
            end
            if (got.sent > peak_sent) peak_sent = got.sent;
            case (got.status)
               ST_OK:      seen_ok++;
               ST_TIMEOUT: seen_timeout++;
               ST_ERROR:   seen_error++;
               default: begin
               end
            endcase
         end
      end
   end

   // receiver side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asks) begin
         hold_served <= hold_asks;
         hold_left   <= LONG_HOLD;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("run stopped after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
   end

   task automatic send_word(input item_type w, input bit typed, input view_type v);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= w.op;
      req_data_byte      <= w.data_byte;
      req_last_byte      <= w.last_byte;
      req_line_not_busy  <= w.not_busy;
      req_line_not_ack   <= w.not_ack;
      req_line_not_error <= w.not_error;
      typed_now          <= typed;
      typed_view         <= v;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic csr_read(input reg_index_type idx, input logic [31:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $display("%0t: register %s expected %0h got %0h", $time, idx.name(), want, csr_prdata);
         errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_TIMEOUT) timeout_shadow = value;
      else strobe_shadow = value[15:0];
      @(negedge clock);
      csr_read(idx, (idx == REG_TIMEOUT) ? timeout_shadow : {16'h0, strobe_shadow});
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_views.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic item_type rand_word();
      item_type w;
      w.op        = ($urandom_range(99) < 30) ? OP_BYTE : OP_TICK;
      w.data_byte = 8'($urandom_range(255));
      w.last_byte = ($urandom_range(99) < 25);
      w.not_busy  = ($urandom_range(99) < 60);
      w.not_ack   = 1'($urandom_range(1));
      w.not_error = ($urandom_range(99) >= 15);
      return w;
   endfunction

   task automatic run_random(input logic [31:0] budget_ticks, input logic [15:0] strobe_len,
                             input int unsigned count, input bit idling, input bit with_hold);
      csr_write(REG_TIMEOUT, budget_ticks);
      csr_write(REG_STROBE, {16'h0, strobe_len});
      idle_on <= idling;
      if (with_hold) hold_asks <= hold_asks + 1;
      @(negedge clock);
      repeat (count) send_word(rand_word(), 1'b0, '0);
      drain();
   endtask

   function automatic step_row_type row(op_type op, logic [7:0] b, logic last, logic nb,
                                        logic na, logic ne, bit typed, view_type v);
      step_row_type r;
      r.word  = item_type'{op, b, last, nb, na, ne};
      r.typed = typed;
      r.view  = v;
      return r;
   endfunction

   initial begin
      step_row_type table_rows[$];
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_read(REG_TIMEOUT, TIMEOUT_RESET);
      csr_read(REG_STROBE, {16'h0, STROBE_RESET});
      // one-tick budget and zero strobe length for the directed words
      csr_write(REG_TIMEOUT, 32'd1);
      csr_write(REG_STROBE, 32'd0);

      table_rows = '{
         row(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
             view_type'{8'h00, 1'b0, 1'b1, ST_BUSY, 16'd0}),
         row(OP_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
             view_type'{8'hFF, 1'b0, 1'b0, ST_BUSY, 16'd0}),
         row(OP_BYTE, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0),
         row(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, '0),
         row(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, '0),
         row(OP_TICK, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0),
         row(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '0),
         row(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, '0),
         row(OP_BYTE, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0),
         row(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
             view_type'{8'h00, 1'b0, 1'b1, ST_TIMEOUT, 16'd1}),
         row(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '0),
         row(OP_BYTE, 8'hA5, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, '0),
         row(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, '0),
         row(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, '0),
         row(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, '0),
         row(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1,
             view_type'{8'hA5, 1'b0, 1'b1, ST_ERROR, 16'd1}),
         row(OP_BYTE, 8'h5A, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0),
         row(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, '0),
         row(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0),
         row(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
             view_type'{8'h5A, 1'b0, 1'b1, ST_OK, 16'd1}),
         row(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0)
      };
      foreach (table_rows[i]) send_word(table_rows[i].word, table_rows[i].typed,
                                        table_rows[i].view);
      typed_now <= 1'b0;
      drain();

      run_random(32'd3, 16'd1, 160, 1'b1, 1'b1);
      // zero budget and zero strobe length
      run_random(32'd0, 16'd0, 110, 1'b1, 1'b0);
      run_random(32'hFFFF_FFFF, 16'd3, 120, 1'b0, 1'b0);
      run_random(32'd2, 16'hFFFF, 100, 1'b1, 1'b0);
      run_random(TIMEOUT_RESET, STROBE_RESET, 110, 1'b1, 1'b0);
      repeat (10) @(negedge clock);

      $display("%0d request words in, %0d response words checked, %0d cycles, peak count %0d",
               words_in, words_out, cycle_count, peak_sent);
      $display("responses showing done ok / timeout / printer error: %0d / %0d / %0d",
               seen_ok, seen_timeout, seen_error);
      if (errors == 0 && expected_views.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
